// ===== hdl/csfw_pkg.sv =====
// ----------------------------------------------------------------------------
// csfw_pkg
// Shared sizes, codes and helpers of the counting semaphore with a FIFO
// wait queue.
// ----------------------------------------------------------------------------
`default_nettype none

package csfw_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int COUNT_BITS  = 16;
	localparam int MAX_RESULTS = 16;

	localparam int ID_W    = 6;
	localparam int AMT_W   = 16;
	localparam int REG_W   = 16;
	localparam int STAT_W  = 3;
	localparam int CNT_W   = COUNT_BITS;
	localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W   = $clog2(QUEUE_DEPTH + 1);
	localparam int REL_W   = $clog2(MAX_RESULTS + 1);
	localparam int SUM_W   = ((CNT_W > AMT_W) ? CNT_W : AMT_W) + 1;
	localparam int LIM_W   = REG_W + CNT_W;
	localparam int ENTRY_W = ID_W + AMT_W;

	typedef enum logic [1:0] {
		FN_INIT   = 2'd0,
		FN_TAKE   = 2'd1,
		FN_GIVE   = 2'd2,
		FN_CANCEL = 2'd3
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		RS_GRANTED     = 3'd0,
		RS_QUEUED      = 3'd1,
		RS_CANCELLED   = 3'd2,
		RS_FULL        = 3'd3,
		RS_NONE        = 3'd4,
		RS_NOT_WAITING = 3'd5,
		RS_INIT        = 3'd6
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_INIT,
		S_TAKE,
		S_GIVE,
		S_REL_RD,
		S_REL_CHK,
		S_REL_END,
		S_CAN_RD,
		S_CAN_CHK,
		S_SH_RD,
		S_SH_WR,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AMT_W-1:0] amt;
	} qent_t;

	// Limit register lowered to the largest count value when it exceeds it.
	function automatic logic [CNT_W-1:0] limit_in_force(input logic [REG_W-1:0] l);
		logic [LIM_W-1:0] lw;
		logic [LIM_W-1:0] mx;
		lw = LIM_W'(l);
		mx = LIM_W'({CNT_W{1'b1}});
		return (lw > mx) ? CNT_W'(mx) : CNT_W'(lw);
	endfunction

	// Advance a ring pointer with wrap at the queue depth.
	function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/csfw_ram.sv =====
// ----------------------------------------------------------------------------
// csfw_ram
// Simple dual-port synchronous RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module csfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Read data holds until the next read.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/counting_semaphore_fifo_waiters.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters
// Counting semaphore whose blocked takers wait in a FIFO held in a RAM ring.
// ----------------------------------------------------------------------------
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------
//  request | req_valid / req_stall | func, requester_id, amount
//  result  | rsp_valid / rsp_stall | waiter_id, granted, status, count_after,
//          |                       | last
//  config  | cfg_we                | cfg_idx, cfg_data (0 limit, 1 initial)
//
//  One request beat at a time: req_stall is high from acceptance until the
//  last result beat of that request is loaded into the output register.
//  Init and take decide the result and then emit it. Give adds the amount,
//  then reads and checks each waiter that it releases, plus the head whose
//  amount the count does not cover when the walk stops there. Cancel reads
//  and checks each entry up to the match, then moves each entry behind it
//  down one slot; every queue access goes through the single RAM port pair,
//  whose read data is registered.
//  Reset clears the count, the ring pointers and the occupancy; the RAM is
//  never cleared since only entries below the occupancy are read.
//  A stalled result beat holds; the walk waits on it before moving on.
//
`default_nettype none

module counting_semaphore_fifo_waiters
	import csfw_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              cfg_we,
	input  wire logic              cfg_idx,
	input  wire logic [REG_W-1:0]  cfg_data,
	// request channel
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire logic [1:0]        func,
	input  wire logic [ID_W-1:0]   requester_id,
	input  wire logic [AMT_W-1:0]  amount,
	// result channel
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [ID_W-1:0]   waiter_id,
	output logic      [AMT_W-1:0]  granted,
	output logic      [STAT_W-1:0] status,
	output logic      [AMT_W-1:0]  count_after,
	output logic                   last
);

	// Configuration registers.
	logic [REG_W-1:0] lim_q;
	logic [REG_W-1:0] init_q;

	// Control state.
	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic [PTR_W-1:0] head_q, head_d;
	logic [PTR_W-1:0] tail_q, tail_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic [REL_W-1:0] rel_q, rel_d;
	logic [OCC_W-1:0] pos_q, pos_d;
	logic [PTR_W-1:0] ptr_q, ptr_d;

	// Captured request beat.
	logic [ID_W-1:0]  id_q;
	logic [AMT_W-1:0] amt_q;

	// Release held back until we know whether it is the final one.
	logic [ID_W-1:0]  pend_id_q, pend_id_d;
	logic [AMT_W-1:0] pend_amt_q, pend_amt_d;
	logic [AMT_W-1:0] pend_cnt_q, pend_cnt_d;

	// Final result of the current request, waiting for the output register.
	logic [ID_W-1:0]  res_id_q, res_id_d;
	logic [AMT_W-1:0] res_gr_q, res_gr_d;
	status_t          res_st_q, res_st_d;
	logic [AMT_W-1:0] res_cnt_q, res_cnt_d;

	// Output register feed.
	logic             out_ld;
	logic             out_free;
	logic [ID_W-1:0]  o_id;
	logic [AMT_W-1:0] o_gr;
	status_t          o_st;
	logic [AMT_W-1:0] o_cnt;
	logic             o_last;
	logic             rsp_valid_q;
	logic [ID_W-1:0]  waiter_id_q;
	logic [AMT_W-1:0] granted_q;
	logic [STAT_W-1:0] status_q;
	logic [AMT_W-1:0] count_after_q;
	logic             last_q;

	// RAM ports.
	logic             ram_we;
	logic [PTR_W-1:0] ram_waddr;
	qent_t            ram_wdata;
	logic             ram_re;
	logic [PTR_W-1:0] ram_raddr;
	qent_t            ram_rdata;

	// Wide views for compares and the saturating add.
	logic [SUM_W-1:0] lim_w;
	logic [SUM_W-1:0] cnt_w;
	logic [SUM_W-1:0] amt_w;
	logic [SUM_W-1:0] head_amt_w;
	logic [SUM_W-1:0] sum_w;
	logic [SUM_W-1:0] init_w;
	logic             req_fire;

	assign lim_w      = SUM_W'(limit_in_force(lim_q));
	assign cnt_w      = SUM_W'(cnt_q);
	assign amt_w      = SUM_W'(amt_q);
	assign head_amt_w = SUM_W'(ram_rdata.amt);
	assign sum_w      = cnt_w + amt_w;
	assign init_w     = SUM_W'(init_q);

	assign req_stall = (state_q != S_IDLE);
	assign req_fire  = req_valid && !req_stall;
	assign out_free  = !rsp_valid_q || !rsp_stall;

	csfw_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Configuration writes; index 0 sets the limit, index 1 the initial count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lim_q  <= REG_W'(1);
			init_q <= '0;
		end else if (cfg_we) begin
			if (cfg_idx == 1'b0) begin
				lim_q <= cfg_data;
			end else begin
				init_q <= cfg_data;
			end
		end
	end

	// Capture the request beat.
	always_ff @(posedge clk) begin
		if (req_fire) begin
			id_q  <= requester_id;
			amt_q <= amount;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			rel_q   <= '0;
			pos_q   <= '0;
			ptr_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			occ_q   <= occ_d;
			rel_q   <= rel_d;
			pos_q   <= pos_d;
			ptr_q   <= ptr_d;
		end
	end

	always_ff @(posedge clk) begin
		pend_id_q  <= pend_id_d;
		pend_amt_q <= pend_amt_d;
		pend_cnt_q <= pend_cnt_d;
		res_id_q   <= res_id_d;
		res_gr_q   <= res_gr_d;
		res_st_q   <= res_st_d;
		res_cnt_q  <= res_cnt_d;
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		head_d     = head_q;
		tail_d     = tail_q;
		occ_d      = occ_q;
		rel_d      = rel_q;
		pos_d      = pos_q;
		ptr_d      = ptr_q;
		pend_id_d  = pend_id_q;
		pend_amt_d = pend_amt_q;
		pend_cnt_d = pend_cnt_q;
		res_id_d   = res_id_q;
		res_gr_d   = res_gr_q;
		res_st_d   = res_st_q;
		res_cnt_d  = res_cnt_q;
		ram_we     = 1'b0;
		ram_waddr  = tail_q;
		ram_wdata  = '{id: id_q, amt: amt_q};
		ram_re     = 1'b0;
		ram_raddr  = head_q;
		out_ld     = 1'b0;
		o_id       = res_id_q;
		o_gr       = res_gr_q;
		o_st       = res_st_q;
		o_cnt      = res_cnt_q;
		o_last     = 1'b1;

		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					pos_d = '0;
					ptr_d = head_q;
					unique case (func_t'(func))
						FN_INIT:   state_d = S_INIT;
						FN_TAKE:   state_d = S_TAKE;
						FN_GIVE:   state_d = S_GIVE;
						FN_CANCEL: state_d = S_CAN_RD;
						default:   state_d = S_IDLE;
					endcase
				end
			end

			// Load the clamped initial count and drop every waiter.
			S_INIT: begin
				cnt_d     = (init_w > lim_w) ? CNT_W'(lim_w) : CNT_W'(init_w);
				occ_d     = '0;
				head_d    = '0;
				tail_d    = '0;
				res_id_d  = '0;
				res_gr_d  = '0;
				res_st_d  = RS_INIT;
				res_cnt_d = AMT_W'(cnt_d);
				state_d   = S_EMIT;
			end

			// Grant at once, else append at the tail, else reject.
			S_TAKE: begin
				res_id_d = id_q;
				res_gr_d = '0;
				if (cnt_w >= amt_w) begin
					cnt_d    = CNT_W'(cnt_w - amt_w);
					res_gr_d = amt_q;
					res_st_d = RS_GRANTED;
				end else if (occ_q < OCC_W'(QUEUE_DEPTH)) begin
					ram_we   = 1'b1;
					tail_d   = ptr_next(tail_q);
					occ_d    = occ_q + OCC_W'(1);
					res_st_d = RS_QUEUED;
				end else begin
					res_st_d = RS_FULL;
				end
				res_cnt_d = AMT_W'(cnt_d);
				state_d   = S_EMIT;
			end

			// Saturating add, then walk the head of the queue.
			S_GIVE: begin
				cnt_d   = (sum_w > lim_w) ? CNT_W'(lim_w) : CNT_W'(sum_w);
				rel_d   = '0;
				state_d = S_REL_RD;
			end

			S_REL_RD: begin
				if (occ_q == '0 || rel_q == REL_W'(MAX_RESULTS)) begin
					state_d = S_REL_END;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = head_q;
					state_d   = S_REL_CHK;
				end
			end

			// Head entry is on the read port. A covered head becomes the new
			// held release; the previous held release goes out with last low.
			S_REL_CHK: begin
				if (cnt_w >= head_amt_w) begin
					if (rel_q == '0 || out_free) begin
						if (rel_q != '0) begin
							out_ld = 1'b1;
							o_id   = pend_id_q;
							o_gr   = pend_amt_q;
							o_st   = RS_GRANTED;
							o_cnt  = pend_cnt_q;
							o_last = 1'b0;
						end
						cnt_d      = CNT_W'(cnt_w - head_amt_w);
						pend_id_d  = ram_rdata.id;
						pend_amt_d = ram_rdata.amt;
						pend_cnt_d = AMT_W'(cnt_d);
						head_d     = ptr_next(head_q);
						occ_d      = occ_q - OCC_W'(1);
						rel_d      = rel_q + REL_W'(1);
						state_d    = S_REL_RD;
					end
				end else begin
					state_d = S_REL_END;
				end
			end

			// Close the walk: the held release is final, or nothing went.
			S_REL_END: begin
				if (rel_q != '0) begin
					res_id_d  = pend_id_q;
					res_gr_d  = pend_amt_q;
					res_st_d  = RS_GRANTED;
					res_cnt_d = pend_cnt_q;
				end else begin
					res_id_d  = id_q;
					res_gr_d  = '0;
					res_st_d  = RS_NONE;
					res_cnt_d = AMT_W'(cnt_q);
				end
				state_d = S_EMIT;
			end

			// Scan from the head for the first matching id.
			S_CAN_RD: begin
				if (pos_q == occ_q) begin
					res_id_d  = id_q;
					res_gr_d  = '0;
					res_st_d  = RS_NOT_WAITING;
					res_cnt_d = AMT_W'(cnt_q);
					state_d   = S_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_q;
					state_d   = S_CAN_CHK;
				end
			end

			S_CAN_CHK: begin
				if (ram_rdata.id == id_q) begin
					state_d = S_SH_RD;
				end else begin
					pos_d   = pos_q + OCC_W'(1);
					ptr_d   = ptr_next(ptr_q);
					state_d = S_CAN_RD;
				end
			end

			// Close the gap: move each later entry down one slot. Reads and
			// writes alternate on different slots, so no forwarding is needed.
			S_SH_RD: begin
				if (ptr_next(ptr_q) == tail_q) begin
					tail_d    = ptr_q;
					occ_d     = occ_q - OCC_W'(1);
					res_id_d  = id_q;
					res_gr_d  = '0;
					res_st_d  = RS_CANCELLED;
					res_cnt_d = AMT_W'(cnt_q);
					state_d   = S_EMIT;
				end else begin
					ram_re    = 1'b1;
					ram_raddr = ptr_next(ptr_q);
					state_d   = S_SH_WR;
				end
			end

			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = ptr_q;
				ram_wdata = ram_rdata;
				ptr_d     = ptr_next(ptr_q);
				state_d   = S_SH_RD;
			end

			// Hand the final result beat to the output register.
			S_EMIT: begin
				if (out_free) begin
					out_ld  = 1'b1;
					state_d = S_IDLE;
				end
			end

			default: state_d = S_IDLE;
		endcase
	end

	// Output register: load on a new beat, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_ld) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_ld) begin
			waiter_id_q   <= o_id;
			granted_q     <= o_gr;
			status_q      <= o_st;
			count_after_q <= o_cnt;
			last_q        <= o_last;
		end
	end

	assign rsp_valid   = rsp_valid_q;
	assign waiter_id   = waiter_id_q;
	assign granted     = granted_q;
	assign status      = status_q;
	assign count_after = count_after_q;
	assign last        = last_q;

endmodule

`default_nettype wire

// ===== sim/counting_semaphore_fifo_waiters_tb.sv =====
// ----------------------------------------------------------------------------
// counting_semaphore_fifo_waiters_tb
// Self-checking bench for the counting semaphore with a FIFO wait queue.
// A directed opening covers zero amounts, saturation, blocking heads,
// duplicate waiters and cancels. Randomized phases follow under several
// limit and initial-count settings, and each phase mixes queue fill-and-drain
// bursts, ordinary traffic and raw noise. An in-bench semaphore model
// predicts every result beat, and a scoreboard checks the DUT against it in
// order.
// ----------------------------------------------------------------------------

module counting_semaphore_fifo_waiters_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import csfw_pkg::*;

	// Configuration register indexes
	localparam logic REG_LIMIT   = 1'b0;
	localparam logic REG_INITIAL = 1'b1;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles without any beat
	localparam int HOLD_AT        = 200;   // request beats before the long hold-off
	localparam int HOLD_CYCLES    = 300;   // length of the long hold-off
	localparam int SETTLE_CYCLES  = 20;    // quiet time after the last result

	typedef struct packed {
		func_t            fn;
		logic [ID_W-1:0]  id;
		logic [AMT_W-1:0] amt;
	} request_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [AMT_W-1:0] granted;
		status_t          st;
		logic [CNT_W-1:0] cnt;
		logic             lst;
	} reply_t;

	// ------------------------------------------------------------------------
	// DUT connections: every input starts at a known value
	// ------------------------------------------------------------------------
	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              cfg_we       = 1'b0;
	logic              cfg_idx      = REG_LIMIT;
	logic [REG_W-1:0]  cfg_data     = '0;
	logic              req_valid    = 1'b0;
	logic              req_stall;
	logic [1:0]        func         = FN_INIT;
	logic [ID_W-1:0]   requester_id = '0;
	logic [AMT_W-1:0]  amount       = '0;
	logic              rsp_valid;
	logic              rsp_stall    = 1'b0;
	logic [ID_W-1:0]   waiter_id;
	logic [AMT_W-1:0]  granted;
	logic [STAT_W-1:0] status;
	logic [AMT_W-1:0]  count_after;
	logic              last;

	counting_semaphore_fifo_waiters u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_idx      (cfg_idx),
		.cfg_data     (cfg_data),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.func         (func),
		.requester_id (requester_id),
		.amount       (amount),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.waiter_id    (waiter_id),
		.granted      (granted),
		.status       (status),
		.count_after  (count_after),
		.last         (last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Semaphore model: shadow registers, count and wait queue
	// ------------------------------------------------------------------------
	logic [REG_W-1:0] sem_limit   = 16'd1;
	logic [REG_W-1:0] sem_initial = 16'd0;
	logic [CNT_W-1:0] sem_count   = '0;
	qent_t            wait_line[$];

	request_t ops_to_send[$];   // filled by the stimulus, drained by the driver
	reply_t   sem_replies[$];   // predicted result beats, oldest first

	bit calm = 1'b0;            // when set, neither side idles at random

	int n_fail       = 0;
	int n_accepted   = 0;
	int n_beats      = 0;
	int n_settings   = 0;
	int n_multi      = 0;
	int longest_walk = 0;
	int status_seen[7];

	// Append one predicted beat; count_after is the count at this point.
	function automatic void push_reply(input logic [ID_W-1:0] rid,
			input logic [AMT_W-1:0] g, input status_t st, input logic lst);
		reply_t r;
		r.id      = rid;
		r.granted = g;
		r.st      = st;
		r.cnt     = sem_count;
		r.lst     = lst;
		sem_replies.push_back(r);
		status_seen[int'(st)]++;
	endfunction

	// Advance the model by one accepted request and queue its result beats.
	// COUNT_BITS equals the register width, so the limit register is the cap.
	function automatic void apply_semaphore_op(input func_t fn,
			input logic [ID_W-1:0] rid, input logic [AMT_W-1:0] ramt);
		logic [CNT_W:0] sum;
		int             released;
		int             hit;
		released = 0;
		hit      = -1;
		case (fn)
			FN_INIT: begin
				// drop every waiter silently, reload the clamped count
				sem_count = (sem_initial > sem_limit) ? sem_limit : sem_initial;
				wait_line.delete();
				push_reply('0, '0, RS_INIT, 1'b1);
			end
			FN_TAKE: begin
				if (sem_count >= ramt) begin
					sem_count = sem_count - ramt;
					push_reply(rid, ramt, RS_GRANTED, 1'b1);
				end else if (wait_line.size() < QUEUE_DEPTH) begin
					wait_line.push_back('{id: rid, amt: ramt});
					push_reply(rid, '0, RS_QUEUED, 1'b1);
				end else begin
					push_reply(rid, '0, RS_FULL, 1'b1);
				end
			end
			FN_GIVE: begin
				sum       = {1'b0, sem_count} + {1'b0, ramt};
				sem_count = (sum > {1'b0, sem_limit}) ? sem_limit : sum[CNT_W-1:0];
				// release from the head while it fits; stop at the first that doesn't
				while (released < MAX_RESULTS && wait_line.size() > 0 &&
						sem_count >= wait_line[0].amt) begin
					sem_count = sem_count - wait_line[0].amt;
					push_reply(wait_line[0].id, wait_line[0].amt, RS_GRANTED, 1'b0);
					void'(wait_line.pop_front());
					released++;
				end
				if (released == 0)
					push_reply(rid, '0, RS_NONE, 1'b1);
				else
					sem_replies[$].lst = 1'b1;
				if (released > 1)
					n_multi++;
				if (released > longest_walk)
					longest_walk = released;
			end
			default: begin
				// cancel the matching waiter nearest the head, keep the rest in order
				foreach (wait_line[i])
					if (hit < 0 && wait_line[i].id == rid)
						hit = i;
				if (hit >= 0) begin
					wait_line.delete(hit);
					push_reply(rid, '0, RS_CANCELLED, 1'b1);
				end else begin
					push_reply(rid, '0, RS_NOT_WAITING, 1'b1);
				end
			end
		endcase
	endfunction

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// ------------------------------------------------------------------------
	// Request driver: one beat at a time from ops_to_send
	// ------------------------------------------------------------------------
	int gap_left;

	always @(posedge clk or negedge arst_n) begin : request_driver
		request_t nxt;
		if (!arst_n) begin
			req_valid    <= 1'b0;
			func         <= FN_INIT;
			requester_id <= '0;
			amount       <= '0;
			gap_left     <= 0;
		end else if (!req_valid || !req_stall) begin
			// the slot is free: either idle or the current beat was just taken
			if (gap_left > 0) begin
				req_valid <= 1'b0;
				gap_left  <= gap_left - 1;
			end else if (ops_to_send.size() > 0) begin
				nxt          = ops_to_send.pop_front();
				req_valid    <= 1'b1;
				func         <= nxt.fn;
				requester_id <= nxt.id;
				amount       <= nxt.amt;
				gap_left     <= calm ? 0 : pick_gap();
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Result receiver: random stalls plus one long hold-off
	// ------------------------------------------------------------------------
	int stall_left;
	int hold_left;
	bit hold_done;

	always @(posedge clk or negedge arst_n) begin : result_receiver
		int g;
		if (!arst_n) begin
			rsp_stall  <= 1'b0;
			stall_left <= 0;
			hold_left  <= 0;
			hold_done  <= 1'b0;
		end else if (!hold_done && n_accepted >= HOLD_AT) begin
			// hold off long enough for the block to back up into its input
			rsp_stall <= 1'b1;
			hold_left <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else if (hold_left > 0) begin
			rsp_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			g          = (calm || $urandom_range(0, 3) != 0) ? 0 : pick_gap();
			rsp_stall  <= (g > 0);
			stall_left <= (g > 0) ? g - 1 : 0;
		end
	end

	// ------------------------------------------------------------------------
	// Monitor: check result beats first, then predict from request beats
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : result_monitor
		reply_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				n_beats++;
				if (sem_replies.size() == 0) begin
					n_fail++;
					if (n_fail <= 10)
						$display({"%0t: unexpected result beat id=%0d granted=%0d",
							" status=%0d count=%0d last=%0b"},
							$realtime, waiter_id, granted, status, count_after, last);
				end else begin
					want = sem_replies.pop_front();
					if (waiter_id !== want.id || granted !== want.granted ||
							status !== want.st || count_after !== want.cnt ||
							last !== want.lst) begin
						n_fail++;
						if (n_fail <= 10)
							$display({"%0t: beat %0d expected id=%0d granted=%0d",
								" status=%0d count=%0d last=%0b, got id=%0d",
								" granted=%0d status=%0d count=%0d last=%0b"},
								$realtime, n_beats, want.id, want.granted, want.st,
								want.cnt, want.lst, waiter_id, granted, status,
								count_after, last);
					end
				end
			end
			if (req_valid && !req_stall) begin
				apply_semaphore_op(func_t'(func), requester_id, amount);
				n_accepted++;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Watchdog: end the run when no beat moves for too long
	// ------------------------------------------------------------------------
	int quiet_cycles = 0;

	always @(posedge clk) begin : watchdog
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no beat for %0d cycles, %0d results still owed",
				WATCHDOG_LIMIT, sem_replies.size());
			$display("[counting_semaphore_fifo_waiters] ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------
	task automatic send(input func_t f, input int rid, input int ramt);
		request_t r;
		r.fn  = f;
		r.id  = ID_W'(rid);
		r.amt = AMT_W'(ramt);
		ops_to_send.push_back(r);
	endtask

	// Wait until every request is taken and every predicted beat has come out.
	task automatic drain();
		while (ops_to_send.size() != 0 || req_valid || sem_replies.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write both registers while the block is idle and update the shadows.
	task automatic configure(input logic [REG_W-1:0] lim, input logic [REG_W-1:0] init_val);
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_idx  <= REG_INITIAL;
		cfg_data <= init_val;
		@(posedge clk);
		cfg_we <= 1'b0;
		sem_limit   = lim;
		sem_initial = init_val;
		n_settings++;
	endtask

	// Small ids most of the time so cancels and duplicates find their waiter.
	function automatic int pick_id();
		return ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 7);
	endfunction

	function automatic int pick_amount(input int span);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return $urandom_range(0, 65535);
		if (r == 1)
			return 0;
		return $urandom_range(1, span);
	endfunction

	// One randomized phase under a fixed setting of both registers.
	task automatic run_phase(input logic [REG_W-1:0] lim, input logic [REG_W-1:0] init_val,
			input bit quiet, input int n_items);
		int made;
		int sel;
		int span;
		int r;
		drain();
		configure(lim, init_val);
		calm = quiet;
		span = int'(lim) / 4 + 1;
		send(FN_INIT, pick_id(), $urandom_range(0, 65535));
		made = 1;
		while (made < n_items) begin
			sel = $urandom_range(0, 19);
			if (sel == 0) begin
				// overfill the wait queue, then let one give walk it
				send(FN_INIT, pick_id(), pick_amount(span));
				repeat ($urandom_range(17, 21)) begin
					send(FN_TAKE, pick_id(), $urandom_range(1, span));
					made++;
				end
				send(FN_GIVE, pick_id(), int'(lim));
				made += 2;
			end else if (sel == 1) begin
				// raw noise across the full field ranges
				repeat (3)
					send(func_t'($urandom_range(0, 3)), $urandom_range(0, 63),
						$urandom_range(0, 65535));
				made += 3;
			end else begin
				r = $urandom_range(0, 19);
				if (r == 0)
					send(FN_INIT, pick_id(), pick_amount(span));
				else if (r < 9)
					send(FN_TAKE, pick_id(), pick_amount(span));
				else if (r < 15)
					send(FN_GIVE, pick_id(), pick_amount(span));
				else
					send(FN_CANCEL, pick_id(), pick_amount(span));
				made++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : stimulus
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed opening: limit 20, initial 5
		configure(16'd20, 16'd5);
		send(FN_INIT,   0,  0);
		send(FN_TAKE,   63, 0);       // zero take is granted at once
		send(FN_TAKE,   1,  5);       // drains the count
		send(FN_TAKE,   2,  3);       // queued
		send(FN_TAKE,   3,  65535);   // queued above the limit: never releasable
		send(FN_TAKE,   2,  1);       // same id waiting twice
		send(FN_GIVE,   0,  0);       // zero give still walks, nothing fits
		send(FN_GIVE,   4,  3);       // releases the head, stops at the blocker
		send(FN_GIVE,   5,  65535);   // saturates at the limit, blocker holds
		send(FN_CANCEL, 3,  0);       // removes the blocker at the head
		send(FN_CANCEL, 3,  0);       // no longer waiting
		send(FN_GIVE,   6,  0);       // now the second waiter for id 2 goes
		send(FN_TAKE,   7,  20);      // queued
		send(FN_TAKE,   8,  1);       // granted although a waiter is queued
		send(FN_CANCEL, 63, 65535);   // id never queued
		send(FN_GIVE,   42, 2);       // exactly covers the head
		send(FN_INIT,   63, 65535);   // fields ignored by init
		send(FN_TAKE,   21, 6);       // queued
		send(FN_INIT,   21, 0);       // drops the waiter without a result
		send(FN_GIVE,   9,  1);       // empty queue: none released

		// Randomized phases across the register extremes
		run_phase(16'd1,     16'd0,     1'b0, 64);
		run_phase(16'hFFFF,  16'hFFFF,  1'b0, 64);
		run_phase(16'd0,     16'd5,     1'b0, 40);  // limit of zero pins the count
		run_phase(16'd20,    16'd7,     1'b1, 64);  // no random idling on either side
		run_phase(16'd300,   16'd0,     1'b0, 64);
		run_phase(16'hFFFF,  16'd30000, 1'b0, 64);

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d requests over %0d register settings, %0d result beats checked",
			n_accepted, n_settings, n_beats);
		$display({"grants %0d, waits %0d, cancels %0d, full rejects %0d, empty gives %0d,",
			" misses %0d, multi-release gives %0d (longest %0d)"},
			status_seen[RS_GRANTED], status_seen[RS_QUEUED], status_seen[RS_CANCELLED],
			status_seen[RS_FULL], status_seen[RS_NONE], status_seen[RS_NOT_WAITING],
			n_multi, longest_walk);
		if (n_fail == 0 && sem_replies.size() == 0)
			$display("[counting_semaphore_fifo_waiters] OK");
		else
			$display("[counting_semaphore_fifo_waiters] ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/csfw_pkg.sv
hdl/csfw_ram.sv
hdl/counting_semaphore_fifo_waiters.sv
sim/counting_semaphore_fifo_waiters_tb.sv
